/* src/ffha_pkg.sv */
// ----------------------------------------------------------------------------
// ffha_pkg: shared types and constants of the first-fit heap allocator
// Holds the segment entry layout, the opcode and status codes, the
// controller-to-datapath command and flag groups, and fixed heap constants.
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

  // Fixed geometry of the heap.
  localparam int unsigned HEADER_BYTES = 32;
  localparam int unsigned ALIGN_BYTES  = 16;

  localparam logic [31:0] HDR        = 32'(HEADER_BYTES);
  localparam logic [31:0] ALIGN_MASK = 32'(ALIGN_BYTES - 1);
  localparam logic [30:0] SIZE_MAX   = 31'h7FFF_FFFF;

  // Register reset values.
  localparam logic [31:0] RESET_BASE  = 32'h0020_0000;
  localparam logic [31:0] RESET_END   = 32'h4000_0000;
  localparam logic [11:0] RESET_SLACK = 12'd64;
  localparam logic [30:0] RESET_SIZE  = 31'(RESET_END - RESET_BASE - HDR);

  // Configuration register indexes.
  localparam logic [1:0] CFG_HEAP_BASE   = 2'd0;
  localparam logic [1:0] CFG_HEAP_END    = 2'd1;
  localparam logic [1:0] CFG_SPLIT_SLACK = 2'd2;

  // Request opcodes.
  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UNSPLIT   = 3'd1;
  localparam logic [2:0] ST_ZERO_SIZE = 3'd2;
  localparam logic [2:0] ST_NO_FIT    = 3'd3;
  localparam logic [2:0] ST_NULL_FREE = 3'd4;
  localparam logic [2:0] ST_BAD_ADDR  = 3'd5;

  // One segment table entry.
  typedef struct packed {
    logic [31:0] start;
    logic [30:0] size;
    logic        used;
  } seg_t;

  // Table read address selection.
  typedef enum logic [2:0] {
    RA_PTR,
    RA_PTR_M1,
    RA_PTR_P1,
    RA_HIT_P1,
    RA_HIT_M1
  } ra_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       accept;
    logic       fresh_wr;
    logic       init_wr;
    logic       ptr_clr;
    logic       ptr_inc;
    logic       ptr_dec;
    ra_sel_e    ra;
    logic       shift_wr;
    logic       split_wr;
    logic       alloc_wr;
    logic       free_wr;
    logic       ins_start;
    logic       hit_latch;
    logic       merge_next;
    logic       merge_prev;
    logic       cnt_dec;
    logic       split_mark;
    logic       set_status;
    logic [2:0] status;
    logic       stat_clr;
    logic       stat_acc;
    logic       out_load;
  } dp_cmd_t;

  // Flags from the datapath to the controller.
  typedef struct packed {
    logic       fresh;
    logic [1:0] op;
    logic       req_zero;
    logic       rel_zero;
    logic       hit_now;
    logic       rd_used;
    logic       last;
    logic       split_ok;
    logic       full;
    logic       nxt_ok;
    logic       prv_ok;
    logic       rm_more;
    logic       ins_more;
    logic       out_free;
  } dp_flag_t;

endpackage

`default_nettype wire

/* src/ffha_dp.sv */
// ----------------------------------------------------------------------------
// ffha_dp: datapath of the first-fit heap allocator
// Segment table memory, pointers, byte counters, configuration registers and
// the result register, all steered by controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_dp #(
  parameter int unsigned MAX_SEGMENTS = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ffha_pkg::dp_cmd_t     cmd_i,
  output ffha_pkg::dp_flag_t         flag_o,
  input  wire logic                  cfg_valid_i,
  input  wire logic [1:0]            cfg_index_i,
  input  wire logic [31:0]           cfg_data_i,
  input  wire logic [1:0]            opcode_i,
  input  wire logic [30:0]           request_size_i,
  input  wire logic [31:0]           release_address_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [2:0]                 status_o,
  output logic [31:0]                data_address_o,
  output logic [30:0]                total_bytes_o,
  output logic [30:0]                used_bytes_o,
  output logic [30:0]                largest_free_o
);

  localparam int unsigned IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);

  // Configuration registers.
  logic [31:0] base_q, end_q;
  logic [11:0] slack_q;

  // Control state.
  logic          fresh_q;
  logic [CW-1:0] count_q, count_d;
  logic [30:0]   used_total_q, used_total_d;
  logic          out_valid_q;

  // Working registers.
  logic [1:0]    op_q;
  logic [31:0]   rounded_q, rel_q;
  logic          split_q;
  logic [IW-1:0] ptr_q, ptr_d, hit_q, hit_d;
  logic [31:0]   cur_start_q, cur_start_d;
  logic [30:0]   cur_size_q, cur_size_d;
  logic [30:0]   tot_q, lrg_q;
  logic [2:0]    status_q;
  logic [31:0]   addr_q;

  // Table memory.
  ffha_pkg::seg_t seg_mem_q [MAX_SEGMENTS];
  ffha_pkg::seg_t rdata_q;
  ffha_pkg::seg_t mem_wd;
  logic [IW-1:0]  mem_wa, mem_ra;
  logic           mem_we;

  // Output payload registers.
  logic [2:0]  out_status_q;
  logic [31:0] out_addr_q;
  logic [30:0] out_tot_q, out_used_q, out_lrg_q;

  // Derived values.
  logic [32:0] init_need, init_diff;
  logic [30:0] init_size;
  logic [32:0] mn_sum, mp_sum;
  logic [30:0] mn_size, mp_size;
  logic [31:0] tot_sum;
  logic [33:0] split_need;
  logic [30:0] alloc_size;
  logic [31:0] rounded_in;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= ffha_pkg::RESET_BASE;
      end_q   <= ffha_pkg::RESET_END;
      slack_q <= ffha_pkg::RESET_SLACK;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ffha_pkg::CFG_HEAP_BASE:   base_q  <= cfg_data_i;
        ffha_pkg::CFG_HEAP_END:    end_q   <= cfg_data_i;
        ffha_pkg::CFG_SPLIT_SLACK: slack_q <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // Init segment size: heap span less one header, saturated to 31 bits.
  always_comb begin
    init_need = {1'b0, base_q} + {1'b0, ffha_pkg::HDR};
    init_diff = ({1'b0, end_q} > init_need) ? ({1'b0, end_q} - init_need) : 33'd0;
    init_size = (init_diff[32:31] != 2'b00) ? ffha_pkg::SIZE_MAX : init_diff[30:0];
  end

  // Coalescing sums with saturation.
  always_comb begin
    mn_sum  = {2'b00, cur_size_q} + {1'b0, ffha_pkg::HDR} + {2'b00, rdata_q.size};
    mn_size = (mn_sum[32:31] != 2'b00) ? ffha_pkg::SIZE_MAX : mn_sum[30:0];
    mp_sum  = {2'b00, rdata_q.size} + {1'b0, ffha_pkg::HDR} + {2'b00, cur_size_q};
    mp_size = (mp_sum[32:31] != 2'b00) ? ffha_pkg::SIZE_MAX : mp_sum[30:0];
  end

  // Rounding, split test and statistics sums.
  assign rounded_in = ({1'b0, request_size_i} + ffha_pkg::ALIGN_MASK) & ~ffha_pkg::ALIGN_MASK;
  assign split_need = {2'b00, rounded_q} + {2'b00, ffha_pkg::HDR} + {22'd0, slack_q};
  assign alloc_size = split_q ? rounded_q[30:0] : cur_size_q;
  assign tot_sum    = {1'b0, tot_q} + {1'b0, rdata_q.size};

  // Table read address.
  always_comb begin
    unique case (cmd_i.ra)
      ffha_pkg::RA_PTR_M1: mem_ra = ptr_q - IW'(1);
      ffha_pkg::RA_PTR_P1: mem_ra = ptr_q + IW'(1);
      ffha_pkg::RA_HIT_P1: mem_ra = hit_q + IW'(1);
      ffha_pkg::RA_HIT_M1: mem_ra = hit_q - IW'(1);
      default:             mem_ra = ptr_q;
    endcase
  end

  // Table write port.
  always_comb begin
    mem_we = 1'b1;
    mem_wa = hit_q;
    mem_wd = '{start: cur_start_q, size: cur_size_q, used: 1'b0};
    priority if (cmd_i.fresh_wr) begin
      mem_wa = '0;
      mem_wd = '{start: ffha_pkg::RESET_BASE, size: ffha_pkg::RESET_SIZE, used: 1'b0};
    end else if (cmd_i.init_wr) begin
      mem_wa = '0;
      mem_wd = '{start: base_q, size: init_size, used: 1'b0};
    end else if (cmd_i.shift_wr) begin
      mem_wa = ptr_q;
      mem_wd = rdata_q;
    end else if (cmd_i.split_wr) begin
      mem_wa = hit_q + IW'(1);
      mem_wd = '{start: cur_start_q + ffha_pkg::HDR + rounded_q,
                 size: 31'(cur_size_q - rounded_q[30:0] - ffha_pkg::HDR[30:0]),
                 used: 1'b0};
    end else if (cmd_i.alloc_wr) begin
      mem_wd = '{start: cur_start_q, size: alloc_size, used: 1'b1};
    end else if (cmd_i.free_wr) begin
      mem_wd = '{start: cur_start_q, size: cur_size_q, used: 1'b0};
    end else begin
      mem_we = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      seg_mem_q[mem_wa] <= mem_wd;
    end
    rdata_q <= seg_mem_q[mem_ra];
  end

  // Pointer, hit index and current segment.
  always_comb begin
    ptr_d       = ptr_q;
    hit_d       = hit_q;
    cur_start_d = cur_start_q;
    cur_size_d  = cur_size_q;
    if (cmd_i.ptr_clr)   ptr_d = '0;
    if (cmd_i.ptr_inc)   ptr_d = ptr_q + IW'(1);
    if (cmd_i.ptr_dec)   ptr_d = ptr_q - IW'(1);
    if (cmd_i.ins_start) ptr_d = IW'(count_q);
    if (cmd_i.hit_latch) begin
      hit_d       = ptr_q;
      cur_start_d = rdata_q.start;
      cur_size_d  = rdata_q.size;
    end
    if (cmd_i.merge_next) begin
      cur_size_d = mn_size;
      ptr_d      = hit_q + IW'(1);
    end
    if (cmd_i.merge_prev) begin
      cur_start_d = rdata_q.start;
      cur_size_d  = mp_size;
      ptr_d       = hit_q;
      hit_d       = hit_q - IW'(1);
    end
  end

  // Segment count and used byte total.
  always_comb begin
    count_d      = count_q;
    used_total_d = used_total_q;
    if (cmd_i.fresh_wr || cmd_i.init_wr) begin
      count_d      = CW'(1);
      used_total_d = '0;
    end
    if (cmd_i.split_wr) count_d = count_q + CW'(1);
    if (cmd_i.cnt_dec)  count_d = count_q - CW'(1);
    if (cmd_i.alloc_wr) used_total_d = used_total_q + alloc_size;
    if (cmd_i.hit_latch && (op_q == ffha_pkg::OP_FREE)) begin
      used_total_d = (used_total_q >= rdata_q.size) ? (used_total_q - rdata_q.size) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q      <= 1'b1;
      count_q      <= CW'(1);
      used_total_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.fresh_wr) fresh_q <= 1'b0;
      count_q      <= count_d;
      used_total_q <= used_total_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk_i) begin
    ptr_q       <= ptr_d;
    hit_q       <= hit_d;
    cur_start_q <= cur_start_d;
    cur_size_q  <= cur_size_d;
    if (cmd_i.accept) begin
      op_q      <= opcode_i;
      rounded_q <= rounded_in;
      rel_q     <= release_address_i;
      split_q   <= 1'b0;
      status_q  <= ffha_pkg::ST_OK;
      addr_q    <= '0;
    end
    if (cmd_i.split_mark) split_q <= 1'b1;
    if (cmd_i.set_status) status_q <= cmd_i.status;
    if (cmd_i.alloc_wr)   addr_q <= cur_start_q + ffha_pkg::HDR;
    if (cmd_i.stat_clr) begin
      tot_q <= '0;
      lrg_q <= '0;
    end
    if (cmd_i.stat_acc) begin
      tot_q <= tot_sum[31] ? ffha_pkg::SIZE_MAX : tot_sum[30:0];
      if (!rdata_q.used && (rdata_q.size > lrg_q)) lrg_q <= rdata_q.size;
    end
    if (cmd_i.out_load) begin
      out_status_q <= status_q;
      out_addr_q   <= addr_q;
      out_tot_q    <= tot_q;
      out_used_q   <= used_total_q;
      out_lrg_q    <= lrg_q;
    end
  end

  // Flags for the controller.
  always_comb begin
    flag_o.fresh    = fresh_q;
    flag_o.op       = op_q;
    flag_o.req_zero = (rounded_q == 32'd0);
    flag_o.rel_zero = (rel_q == 32'd0);
    flag_o.hit_now  = (op_q == ffha_pkg::OP_ALLOC)
                    ? (!rdata_q.used && ({1'b0, rdata_q.size} >= rounded_q))
                    : ((rdata_q.start + ffha_pkg::HDR) == rel_q);
    flag_o.rd_used  = rdata_q.used;
    flag_o.last     = ((CW'(ptr_q) + CW'(1)) == count_q);
    flag_o.split_ok = ({3'b000, cur_size_q} >= split_need);
    flag_o.full     = (count_q == CW'(MAX_SEGMENTS));
    flag_o.nxt_ok   = ((CW'(hit_q) + CW'(1)) < count_q);
    flag_o.prv_ok   = (hit_q != '0);
    flag_o.rm_more  = ((CW'(ptr_q) + CW'(1)) < count_q);
    flag_o.ins_more = (CW'(ptr_q) > (CW'(hit_q) + CW'(1)));
    flag_o.out_free = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign data_address_o = out_addr_q;
  assign total_bytes_o  = out_tot_q;
  assign used_bytes_o   = out_used_q;
  assign largest_free_o = out_lrg_q;

`ifndef SYNTHESIS
  // The table never empties and never outgrows its memory.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) && (count_q <= CW'(MAX_SEGMENTS)))
    else $error("segment count out of range");

  // A split only happens while a table slot is free.
  a_split_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.split_wr |-> (count_q < CW'(MAX_SEGMENTS)))
    else $error("split into a full table");

  // A result is loaded only when the previous one has gone.
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire

/* src/ffha_ctrl.sv */
// ----------------------------------------------------------------------------
// ffha_ctrl: sequencing controller of the first-fit heap allocator
// Walks each request through search, shift, write-back and statistics scans,
// issuing one command group to the datapath per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire ffha_pkg::dp_flag_t flag_i,
  output ffha_pkg::dp_cmd_t       cmd_o
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_FRESH    = 5'd1;
  localparam logic [4:0] S_DECODE   = 5'd2;
  localparam logic [4:0] S_SRCH_RD  = 5'd3;
  localparam logic [4:0] S_SRCH_EV  = 5'd4;
  localparam logic [4:0] S_HIT      = 5'd5;
  localparam logic [4:0] S_INS_RD   = 5'd6;
  localparam logic [4:0] S_INS_WR   = 5'd7;
  localparam logic [4:0] S_SPLIT_WR = 5'd8;
  localparam logic [4:0] S_ALLOC_WR = 5'd9;
  localparam logic [4:0] S_NXT_RD   = 5'd10;
  localparam logic [4:0] S_NXT_EV   = 5'd11;
  localparam logic [4:0] S_PRV_RD   = 5'd12;
  localparam logic [4:0] S_PRV_EV   = 5'd13;
  localparam logic [4:0] S_RM_RD    = 5'd14;
  localparam logic [4:0] S_RM_WR    = 5'd15;
  localparam logic [4:0] S_FREE_WR  = 5'd16;
  localparam logic [4:0] S_ST_CLR   = 5'd17;
  localparam logic [4:0] S_ST_RD    = 5'd18;
  localparam logic [4:0] S_ST_EV    = 5'd19;
  localparam logic [4:0] S_DONE     = 5'd20;

  logic [4:0] state_q, state_d;
  logic       ret_prv_q, ret_prv_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ret_prv_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ret_prv_q <= ret_prv_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_d   = state_q;
    ret_prv_d = ret_prv_q;
    cmd_o     = '0;
    cmd_o.ra  = ffha_pkg::RA_PTR;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_FRESH;
        end
      end
      // The table holds its reset segment only after the first write.
      S_FRESH: begin
        cmd_o.fresh_wr = flag_i.fresh;
        state_d        = S_DECODE;
      end
      S_DECODE: begin
        cmd_o.ptr_clr = 1'b1;
        unique case (flag_i.op)
          ffha_pkg::OP_INIT: begin
            cmd_o.init_wr = 1'b1;
            state_d       = S_ST_CLR;
          end
          ffha_pkg::OP_ALLOC: begin
            if (flag_i.req_zero) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ffha_pkg::ST_ZERO_SIZE;
              state_d          = S_ST_CLR;
            end else begin
              state_d = S_SRCH_RD;
            end
          end
          ffha_pkg::OP_FREE: begin
            if (flag_i.rel_zero) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ffha_pkg::ST_NULL_FREE;
              state_d          = S_ST_CLR;
            end else begin
              state_d = S_SRCH_RD;
            end
          end
          default: state_d = S_ST_CLR;
        endcase
      end
      // Linear search, one entry per read and evaluate pair.
      S_SRCH_RD: state_d = S_SRCH_EV;
      S_SRCH_EV: begin
        if (flag_i.hit_now && (flag_i.op == ffha_pkg::OP_FREE) && !flag_i.rd_used) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ffha_pkg::ST_BAD_ADDR;
          state_d          = S_ST_CLR;
        end else if (flag_i.hit_now) begin
          cmd_o.hit_latch = 1'b1;
          state_d = (flag_i.op == ffha_pkg::OP_ALLOC) ? S_HIT : S_NXT_RD;
        end else if (flag_i.last) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = (flag_i.op == ffha_pkg::OP_ALLOC) ? ffha_pkg::ST_NO_FIT
                                                                : ffha_pkg::ST_BAD_ADDR;
          state_d          = S_ST_CLR;
        end else begin
          cmd_o.ptr_inc = 1'b1;
          state_d       = S_SRCH_RD;
        end
      end
      // Decide whether the fitting segment is split.
      S_HIT: begin
        if (flag_i.split_ok && !flag_i.full) begin
          cmd_o.split_mark = 1'b1;
          cmd_o.ins_start  = 1'b1;
          state_d          = S_INS_RD;
        end else begin
          if (flag_i.split_ok) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = ffha_pkg::ST_UNSPLIT;
          end
          state_d = S_ALLOC_WR;
        end
      end
      // Open a slot above the hit by moving entries up.
      S_INS_RD: begin
        cmd_o.ra = ffha_pkg::RA_PTR_M1;
        state_d  = flag_i.ins_more ? S_INS_WR : S_SPLIT_WR;
      end
      S_INS_WR: begin
        cmd_o.shift_wr = 1'b1;
        cmd_o.ptr_dec  = 1'b1;
        state_d        = S_INS_RD;
      end
      S_SPLIT_WR: begin
        cmd_o.split_wr = 1'b1;
        state_d        = S_ALLOC_WR;
      end
      S_ALLOC_WR: begin
        cmd_o.alloc_wr = 1'b1;
        state_d        = S_ST_CLR;
      end
      // Merge with a free following segment.
      S_NXT_RD: begin
        cmd_o.ra = ffha_pkg::RA_HIT_P1;
        state_d  = flag_i.nxt_ok ? S_NXT_EV : S_PRV_RD;
      end
      S_NXT_EV: begin
        if (!flag_i.rd_used) begin
          cmd_o.merge_next = 1'b1;
          ret_prv_d        = 1'b1;
          state_d          = S_RM_RD;
        end else begin
          state_d = S_PRV_RD;
        end
      end
      // Merge into a free preceding segment.
      S_PRV_RD: begin
        cmd_o.ra = ffha_pkg::RA_HIT_M1;
        state_d  = flag_i.prv_ok ? S_PRV_EV : S_FREE_WR;
      end
      S_PRV_EV: begin
        if (!flag_i.rd_used) begin
          cmd_o.merge_prev = 1'b1;
          ret_prv_d        = 1'b0;
          state_d          = S_RM_RD;
        end else begin
          state_d = S_FREE_WR;
        end
      end
      // Close the gap of a removed entry by moving entries down.
      S_RM_RD: begin
        cmd_o.ra = ffha_pkg::RA_PTR_P1;
        if (flag_i.rm_more) begin
          state_d = S_RM_WR;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = ret_prv_q ? S_PRV_RD : S_FREE_WR;
        end
      end
      S_RM_WR: begin
        cmd_o.shift_wr = 1'b1;
        cmd_o.ptr_inc  = 1'b1;
        state_d        = S_RM_RD;
      end
      S_FREE_WR: begin
        cmd_o.free_wr = 1'b1;
        state_d       = S_ST_CLR;
      end
      // Statistics scan over the whole table.
      S_ST_CLR: begin
        cmd_o.ptr_clr  = 1'b1;
        cmd_o.stat_clr = 1'b1;
        state_d        = S_ST_RD;
      end
      S_ST_RD: state_d = S_ST_EV;
      S_ST_EV: begin
        cmd_o.stat_acc = 1'b1;
        if (flag_i.last) begin
          state_d = S_DONE;
        end else begin
          cmd_o.ptr_inc = 1'b1;
          state_d       = S_ST_RD;
        end
      end
      S_DONE: begin
        if (flag_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  // An accepted request always goes to the reset-entry check next.
  a_accept_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (state_q == S_FRESH))
    else $error("accept did not start a request");

  // Table writes never coincide with a request being accepted.
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !(cmd_o.shift_wr || cmd_o.split_wr || cmd_o.alloc_wr
                              || cmd_o.free_wr || cmd_o.init_wr))
    else $error("table write while idle");

  // A result is only loaded from the final state.
  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> (state_q == S_IDLE))
    else $error("result load outside completion");
`endif

endmodule

`default_nettype wire

/* src/first_fit_heap_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_heap_allocator: hardware first-fit heap with split and coalesce
// Top level joining the sequencing controller and the segment table datapath.
// ----------------------------------------------------------------------------
// Takes one request at a time (init, allocate or free) and returns one result
// with status, data address and total, used and largest-free byte counts. The
// segment table lives in a single-port-write, registered-read memory, so every
// table visit is a read followed by an evaluate or write step: first-fit or
// address search, opening or closing a slot, and the closing statistics scan
// each step through the table one entry at a time, bounded by the current
// segment count (up to MAX_SEGMENTS). A new request is accepted while the last
// result still waits at the output. The first request after reset also writes
// the reset segment. Configuration writes are taken at any time; heap base and
// end apply at the next init request, split slack at the next split decision.
`default_nettype none

module first_fit_heap_allocator #(
  parameter int unsigned MAX_SEGMENTS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [30:0] request_size_i,
  input  wire logic [31:0] release_address_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [31:0]      data_address_o,
  output logic [30:0]      total_bytes_o,
  output logic [30:0]      used_bytes_o,
  output logic [30:0]      largest_free_o
);

  ffha_pkg::dp_cmd_t  cmd;
  ffha_pkg::dp_flag_t flag;

  // Registers accept writes at any time.
  assign cfg_ready_o = 1'b1;

  ffha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .flag_i     (flag),
    .cmd_o      (cmd)
  );

  ffha_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .flag_o            (flag),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .opcode_i          (opcode_i),
    .request_size_i    (request_size_i),
    .release_address_i (release_address_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .data_address_o    (data_address_o),
    .total_bytes_o     (total_bytes_o),
    .used_bytes_o      (used_bytes_o),
    .largest_free_o    (largest_free_o)
  );

endmodule

`default_nettype wire

/* sim/ffha_checker.sv */
// ----------------------------------------------------------------------------
// ffha_checker: result predictor and scoreboard for the first-fit allocator
// Follows the configuration writes and accepted requests, keeps its own copy
// of the segment table, and compares every accepted result in order.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_checker
  import ffha_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [30:0] request_size_i,
  input  wire logic [31:0] release_address_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire logic [2:0]  status_i,
  input  wire logic [31:0] data_address_i,
  input  wire logic [30:0] total_bytes_i,
  input  wire logic [30:0] used_bytes_i,
  input  wire logic [30:0] largest_free_i,
  output int unsigned      fail_count_o,
  output int unsigned      outstanding_o
);

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] addr;
    logic [30:0] total;
    logic [30:0] used;
    logic [30:0] largest;
  } heap_result_t;

  // Shadow configuration and segment table.
  logic [31:0] base_q, end_q;
  logic [11:0] slack_q;
  logic [31:0] seg_start [MAX_SEGMENTS];
  logic [30:0] seg_size  [MAX_SEGMENTS];
  logic        seg_used  [MAX_SEGMENTS];
  int unsigned seg_count;
  logic [30:0] used_sum;

  heap_result_t pending_results[$];
  int unsigned  fails;

  assign fail_count_o  = fails;
  assign outstanding_o = pending_results.size();

  task automatic rebuild_heap();
    logic [32:0] need;
    logic [32:0] span;
    span = {1'b0, end_q};
    need = {1'b0, base_q} + 33'(HEADER_BYTES);
    span = (span > need) ? span - need : 33'd0;
    seg_start[0] = base_q;
    seg_size[0]  = (span > 33'(SIZE_MAX)) ? SIZE_MAX : span[30:0];
    seg_used[0]  = 1'b0;
    seg_count    = 1;
    used_sum     = '0;
  endtask

  // Absorb entry idx+1 into entry idx and close the gap.
  task automatic absorb_next(int unsigned idx);
    logic [32:0] s;
    s = 33'(seg_size[idx]) + 33'(HEADER_BYTES) + 33'(seg_size[idx+1]);
    seg_size[idx] = (s > 33'(SIZE_MAX)) ? SIZE_MAX : s[30:0];
    for (int unsigned k = idx + 1; k + 1 < seg_count; k++) begin
      seg_start[k] = seg_start[k+1];
      seg_size[k]  = seg_size[k+1];
      seg_used[k]  = seg_used[k+1];
    end
    seg_count--;
  endtask

  // Apply one request to the shadow table and return its result.
  task automatic apply_request(input logic [1:0] op, input logic [30:0] req,
                               input logic [31:0] rel, output heap_result_t r);
    logic [33:0] rounded;
    logic [33:0] total;
    int unsigned i;
    r = '0;
    if (op == OP_INIT) begin
      rebuild_heap();
    end else if (op == OP_ALLOC) begin
      if (req == '0) begin
        r.status = ST_ZERO_SIZE;
      end else begin
        rounded = ((34'(req) + 34'(ALIGN_BYTES - 1)) / ALIGN_BYTES) * ALIGN_BYTES;
        for (i = 0; i < seg_count; i++)
          if (!seg_used[i] && 34'(seg_size[i]) >= rounded) break;
        if (i >= seg_count) begin
          r.status = ST_NO_FIT;
        end else begin
          r.status = ST_OK;
          if (34'(seg_size[i]) >= rounded + 34'(HEADER_BYTES) + 34'(slack_q)) begin
            if (seg_count >= MAX_SEGMENTS) begin
              r.status = ST_UNSPLIT;
            end else begin
              for (int unsigned k = seg_count; k > i + 1; k--) begin
                seg_start[k] = seg_start[k-1];
                seg_size[k]  = seg_size[k-1];
                seg_used[k]  = seg_used[k-1];
              end
              seg_start[i+1] = seg_start[i] + HDR + rounded[31:0];
              seg_size[i+1]  = 31'(34'(seg_size[i]) - rounded - 34'(HEADER_BYTES));
              seg_used[i+1]  = 1'b0;
              seg_size[i]    = rounded[30:0];
              seg_count++;
            end
          end
          seg_used[i] = 1'b1;
          used_sum    = used_sum + seg_size[i];
          r.addr      = seg_start[i] + HDR;
        end
      end
    end else if (op == OP_FREE) begin
      if (rel == '0) begin
        r.status = ST_NULL_FREE;
      end else begin
        for (i = 0; i < seg_count; i++)
          if (seg_start[i] + HDR == rel) break;
        if (i >= seg_count || !seg_used[i]) begin
          r.status = ST_BAD_ADDR;
        end else begin
          r.status    = ST_OK;
          seg_used[i] = 1'b0;
          used_sum    = (used_sum >= seg_size[i]) ? used_sum - seg_size[i] : '0;
          if (i + 1 < seg_count && !seg_used[i+1]) absorb_next(i);
          if (i > 0 && !seg_used[i-1]) absorb_next(i - 1);
        end
      end
    end
    // Statistics over the whole table.
    total = '0;
    for (i = 0; i < seg_count; i++) begin
      total = total + 34'(seg_size[i]);
      if (!seg_used[i] && seg_size[i] > r.largest) r.largest = seg_size[i];
    end
    r.total = (total > 34'(SIZE_MAX)) ? SIZE_MAX : total[30:0];
    r.used  = used_sum;
  endtask

  // Track configuration, predict requests and compare results.
  always @(posedge clk_i or negedge rst_ni) begin
    heap_result_t exp_r;
    heap_result_t got_r;
    if (!rst_ni) begin
      base_q  <= RESET_BASE;
      end_q   <= RESET_END;
      slack_q <= RESET_SLACK;
      fails   <= 0;
      pending_results.delete();
      base_q   = RESET_BASE;
      end_q    = RESET_END;
      rebuild_heap();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_HEAP_BASE:   base_q  = cfg_data_i;
          CFG_HEAP_END:    end_q   = cfg_data_i;
          CFG_SPLIT_SLACK: slack_q = cfg_data_i[11:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        got_r = {status_i, data_address_i, total_bytes_i, used_bytes_i, largest_free_i};
        if (pending_results.size() == 0) begin
          if (fails < 10) $display("ERROR: unexpected result %p", got_r);
          fails = fails + 1;
        end else begin
          exp_r = pending_results.pop_front();
          if (got_r !== exp_r) begin
            if (fails < 10)
              $display("ERROR: result mismatch expected %p actual %p", exp_r, got_r);
            fails = fails + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        apply_request(opcode_i, request_size_i, release_address_i, exp_r);
        pending_results.push_back(exp_r);
      end
    end
  end

endmodule

`default_nettype wire

/* sim/tb_first_fit_heap_allocator.sv */
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator: stimulus and verdict for the heap allocator
// Drives directed and random init, allocate and free requests under several
// configurations and idling patterns; the checker scores every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_first_fit_heap_allocator;
  import ffha_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  opcode_i = '0;
  logic [30:0] request_size_i = '0;
  logic [31:0] release_address_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [31:0] data_address_o;
  logic [30:0] total_bytes_o, used_bytes_o, largest_free_o;

  int unsigned fail_count, outstanding;
  int unsigned sent_count = 0, done_count = 0;
  int unsigned send_idle_pct = 0, recv_stall_pct = 0;
  logic [31:0] live_addrs[$];
  logic [31:0] freed_addrs[$];

  first_fit_heap_allocator uut (.*);

  ffha_checker checker_i (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i,
    .cfg_data_i, .in_valid_i, .in_stall_i(in_stall_o), .opcode_i,
    .request_size_i, .release_address_i, .out_valid_i(out_valid_o),
    .out_stall_i, .status_i(status_o), .data_address_i(data_address_o),
    .total_bytes_i(total_bytes_o), .used_bytes_i(used_bytes_o),
    .largest_free_i(largest_free_o), .fail_count_o(fail_count),
    .outstanding_o(outstanding)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #400_000_000;
    $display("Verification failed");
    $finish;
  end

  // Receiver stalls and harvest of granted addresses for later frees.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      done_count <= done_count + 1;
      if ((status_o == ST_OK || status_o == ST_UNSPLIT) && data_address_o != '0)
        live_addrs.push_back(data_address_o);
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_request(logic [1:0] op, logic [30:0] sz, logic [31:0] rel);
    logic taken;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    opcode_i          <= op;
    request_size_i    <= sz;
    release_address_i <= rel;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    sent_count++;
  endtask

  // Drop valid and wait until every request has its result.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (done_count != sent_count) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    logic taken;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_heap(logic [31:0] b, logic [31:0] e, logic [11:0] s);
    drain();
    write_reg(CFG_HEAP_BASE, b);
    write_reg(CFG_HEAP_END, e);
    write_reg(CFG_SPLIT_SLACK, {20'd0, s});
    send_request(OP_INIT, '0, '0);
    drain();
    live_addrs.delete();
    freed_addrs.delete();
  endtask

  // One random request, mostly well-formed allocate and free traffic.
  task automatic random_request();
    int unsigned pick, idx;
    logic [31:0] a;
    pick = $urandom_range(99);
    if (pick < 55) begin
      if ($urandom_range(19) == 0)
        send_request(OP_ALLOC, 31'($urandom), '0);
      else if ($urandom_range(9) == 0)
        send_request(OP_ALLOC, 31'($urandom_range(65536)), '0);
      else
        send_request(OP_ALLOC, 31'($urandom_range(512)), '0);
    end else if (pick < 90 && live_addrs.size() != 0) begin
      idx = $urandom_range(live_addrs.size() - 1);
      a = live_addrs[idx];
      live_addrs.delete(idx);
      freed_addrs.push_back(a);
      send_request(OP_FREE, '0, a);
    end else if (pick < 94 && freed_addrs.size() != 0) begin
      send_request(OP_FREE, '0, freed_addrs[$urandom_range(freed_addrs.size() - 1)]);
    end else if (pick < 97) begin
      send_request(OP_FREE, '0, ($urandom_range(3) == 0) ? 32'd0 : $urandom);
    end else if (pick < 98) begin
      send_request(2'd3, 31'($urandom), $urandom);
    end else begin
      drain();
      send_request(OP_INIT, '0, '0);
      drain();
      live_addrs.delete();
      freed_addrs.delete();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests on the reset configuration.
    send_request(2'd3, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_ALLOC, '0, '0);
    send_request(OP_ALLOC, 31'd1, '0);
    send_request(OP_ALLOC, 31'h7FFF_FFFF, '0);
    send_request(OP_ALLOC, 31'h4000_0000, '0);
    send_request(OP_FREE, '0, '0);
    send_request(OP_FREE, '0, 32'hFFFF_FFFF);
    send_request(OP_FREE, '0, 32'h0020_0020);
    send_request(OP_FREE, '0, 32'h0020_0020);
    send_request(OP_INIT, '0, '0);

    // Full 32-bit span saturates the size; then the smallest heaps.
    set_heap(32'h0000_0000, 32'hFFFF_FFFF, 12'd0);
    send_request(OP_ALLOC, 31'h4000_0000, '0);
    send_request(OP_ALLOC, 31'h3FFF_FFF0, '0);
    set_heap(32'd100, 32'd132, 12'd4095);
    send_request(OP_ALLOC, 31'd1, '0);
    set_heap(32'hFFFF_FFF0, 32'd8, 12'd64);
    send_request(OP_ALLOC, 31'd1, '0);
    set_heap(32'hFFFF_F000, 32'hFFFF_FFFF, 12'd0);
    repeat (8) send_request(OP_ALLOC, 31'd500, '0);

    // Random phases with different configurations and idling.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;  recv_stall_pct = 0;
          set_heap(RESET_BASE, RESET_END, 12'd0);
        end
        1: begin
          send_idle_pct = 56; recv_stall_pct = 0;
          set_heap(32'h0000_1000, 32'h0000_5000, 12'd4095);
        end
        2: begin
          send_idle_pct = 0;  recv_stall_pct = 56;
          set_heap($urandom, $urandom, 12'($urandom));
          send_request(OP_ALLOC, 31'd16, '0);
          set_heap(32'h0001_0000 + ($urandom & 32'hFFF0), 32'h0010_0000, 12'd128);
        end
        default: begin
          send_idle_pct = 12; recv_stall_pct = 12;
          set_heap(32'h0000_0000, 32'hFFFF_FFFF, 12'd64);
        end
      endcase
      for (int n = 0; n < 320; n++) begin
        random_request();
        if (n == 160) drain();
      end
    end

    drain();
    repeat (400) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

/* first_fit_heap_allocator.f */
src/ffha_pkg.sv
src/ffha_dp.sv
src/ffha_ctrl.sv
src/first_fit_heap_allocator.sv
sim/ffha_checker.sv
sim/tb_first_fit_heap_allocator.sv
